/* rtl/ngram_text_scorer_defines.svh */
// ----------------------------------------------------------------------------
// ngram_text_scorer_defines
// Assertion macros shared by the n-gram scorer RTL. Each macro expects the
// names aclk and aresetn in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef NGRAM_TEXT_SCORER_DEFINES_SVH
`define NGRAM_TEXT_SCORER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NGTS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NGTS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ngts_pkg.sv */
// ----------------------------------------------------------------------------
// ngts_pkg
// Types and constants shared by the n-gram text scorer modules.
// ----------------------------------------------------------------------------
package ngts_pkg;

    localparam int NGRAM_LEN_DEF = 3;
    localparam int ALPHABET      = 26;

    localparam int LETTER_W  = 5;
    localparam int INDEX_W   = 15;
    localparam int VALUE_W   = 16;
    localparam int SUM_W     = 32;
    localparam int SEEN_W    = 3;
    localparam int S_DATA_W  = 40;
    localparam int S_USER_W  = 3;

    localparam logic [VALUE_W-1:0] UNSEEN_RESET = 16'h8000;

    typedef enum logic [1:0] {
        MODE_PRIOR = 2'd0,
        MODE_COND  = 2'd1,
        MODE_TEXT  = 2'd2
    } mode_t;

    // One stored table entry: present mark and Q7.8 log probability.
    typedef struct packed {
        logic                      present;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    // Control that travels with a letter from the read stage to the adder.
    typedef struct packed {
        logic first;
        logic last;
        logic add_cond;
        logic add_prior;
        logic too_short;
    } ctl_t;

endpackage

/* rtl/ngts_table.sv */
// ----------------------------------------------------------------------------
// ngts_table
// Single-clock table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ngts_table import ngts_pkg::*; #(
    parameter int DEPTH = ALPHABET ** NGRAM_LEN_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ngts_window.sv */
// ----------------------------------------------------------------------------
// ngts_window
// Letter window and count: forms the table read addresses for each letter
// and registers the control that goes with the read data.
// ----------------------------------------------------------------------------
module ngts_window import ngts_pkg::*; #(
    parameter int NGRAM_LEN = NGRAM_LEN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         take,
    input  logic [LETTER_W-1:0]          letter,
    input  logic                         first,
    input  logic                         last,
    output logic [$clog2(ALPHABET ** NGRAM_LEN)-1:0]       cond_addr,
    output logic [$clog2(ALPHABET ** (NGRAM_LEN - 1))-1:0] prior_addr,
    output ctl_t                         ctl
);

    localparam int COND_AW  = $clog2(ALPHABET ** NGRAM_LEN);
    localparam int PRIOR_AW = $clog2(ALPHABET ** (NGRAM_LEN - 1));
    localparam int DIGITS   = NGRAM_LEN - 1;

    // Most recent letter in entry 0.
    logic [LETTER_W-1:0] dig_reg  [DIGITS];
    logic [LETTER_W-1:0] dig_next [DIGITS];
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    ctl_t                ctl_reg, ctl_next;

    logic [LETTER_W-1:0] letter_sat;
    logic [SEEN_W-1:0]   seen_base;
    logic [SEEN_W-1:0]   seen_inc;

    assign letter_sat = (letter > LETTER_W'(ALPHABET - 1)) ? LETTER_W'(ALPHABET - 1) : letter;
    assign seen_base  = first ? '0 : seen_reg;
    assign seen_inc   = (seen_base < SEEN_W'(NGRAM_LEN + 1)) ? seen_base + 1'b1 : seen_base;

    // Base-26 addresses, oldest letter most significant.
    always_comb begin
        logic [COND_AW-1:0]  acc_c;
        logic [COND_AW-1:0]  acc_p;
        logic [LETTER_W-1:0] base_d;
        acc_c = '0;
        acc_p = '0;
        for (int k = DIGITS - 1; k >= 0; k--) begin
            base_d = first ? '0 : dig_reg[k];
            acc_c  = acc_c * COND_AW'(ALPHABET) + COND_AW'(base_d);
            if (k < DIGITS - 1) begin
                acc_p = acc_p * COND_AW'(ALPHABET) + COND_AW'(base_d);
            end
        end
        cond_addr  = acc_c * COND_AW'(ALPHABET) + COND_AW'(letter_sat);
        acc_p      = acc_p * COND_AW'(ALPHABET) + COND_AW'(letter_sat);
        prior_addr = acc_p[PRIOR_AW-1:0];
    end

    always_comb begin
        seen_next = seen_reg;
        for (int k = 0; k < DIGITS; k++) begin
            dig_next[k] = dig_reg[k];
        end
        ctl_next = ctl_reg;
        if (take) begin
            ctl_next.first     = first;
            ctl_next.last      = last;
            ctl_next.add_cond  = (seen_base >= SEEN_W'(NGRAM_LEN - 1));
            ctl_next.add_prior = (seen_base == SEEN_W'(NGRAM_LEN - 2));
            ctl_next.too_short = (seen_inc <= SEEN_W'(NGRAM_LEN));
            if (last) begin
                // A closed string leaves a fresh window behind it.
                seen_next = '0;
                for (int k = 0; k < DIGITS; k++) begin
                    dig_next[k] = '0;
                end
            end else begin
                seen_next   = seen_inc;
                dig_next[0] = letter_sat;
                for (int k = 1; k < DIGITS; k++) begin
                    dig_next[k] = first ? '0 : dig_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            for (int k = 0; k < DIGITS; k++) begin
                dig_reg[k] <= '0;
            end
        end else begin
            seen_reg <= seen_next;
            for (int k = 0; k < DIGITS; k++) begin
                dig_reg[k] <= dig_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        ctl_reg <= ctl_next;
    end

    assign ctl = ctl_reg;

endmodule

/* rtl/ngts_accum.sv */
// ----------------------------------------------------------------------------
// ngts_accum
// Saturating score accumulator and result register.
// ----------------------------------------------------------------------------
module ngts_accum import ngts_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  ctl_t               ctl,
    input  entry_t             cond_entry,
    input  entry_t             prior_entry,
    input  logic [VALUE_W-1:0] unseen_score,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [SUM_W-1:0]   m_tdata,    // [31:0] total_score
    output logic [0:0]         m_tuser     // [0] too_short
);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_data_reg, out_data_next;
    logic             out_short_reg, out_short_next;

    logic [VALUE_W-1:0] addend;
    logic [SUM_W-1:0]   sum_base;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;

    always_comb begin
        if (ctl.add_cond) begin
            addend = cond_entry.present ? cond_entry.value : unseen_score;
        end else if (ctl.add_prior && prior_entry.present) begin
            addend = prior_entry.value;
        end else begin
            addend = '0;
        end
    end

    assign sum_base = ctl.first ? '0 : sum_reg;
    assign sum_wide = {sum_base[SUM_W-1], sum_base}
                    + {{(SUM_W - VALUE_W + 1){addend[VALUE_W-1]}}, addend};

    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    always_comb begin
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_short_next = out_short_reg;
        if (fire) begin
            if (ctl.last) begin
                sum_next       = '0;
                out_valid_next = 1'b1;
                out_data_next  = sum_sat;
                out_short_next = ctl.too_short;
            end else begin
                sum_next = sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_short_reg <= out_short_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_short_reg;

endmodule

/* rtl/ngram_text_scorer.sv */
// ----------------------------------------------------------------------------
// ngram_text_scorer
// Scores letter strings under an n-gram model held in two on-chip tables.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the adder stage is not stalled:
// a prior load, a conditional load or a text letter. Each letter reads both
// tables at the edge that accepts it; the adder stage then adds the read data
// to the running sum, and the score of a closed string is written to the
// output register when the adder stage takes its last letter. The rate is set
// by the single read port of each table, which serves one letter per cycle.
// After reset both tables are cleared one entry per cycle, over the
// ALPHABET**NGRAM_LEN entries of the conditional table (17576 for trigrams); no
// input request is taken until that pass is done, while configuration writes are taken at any time.
module ngram_text_scorer import ngts_pkg::*; #(
    parameter int NGRAM_LEN = NGRAM_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [14:0] table_index, [30:15] log_value,
                                           // [35:31] letter, [39:36] zero
    input  logic [S_USER_W-1:0] s_tuser,   // [1:0] mode, [2] first_letter
    input  logic                s_tlast,   // last_letter
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SUM_W-1:0]    m_tdata,   // [31:0] total_score
    output logic [0:0]          m_tuser,   // [0] too_short
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [VALUE_W-1:0]  cfg_data
);

`include "ngram_text_scorer_defines.svh"

    localparam int PRIOR_DEPTH = ALPHABET ** (NGRAM_LEN - 1);
    localparam int COND_DEPTH  = ALPHABET ** NGRAM_LEN;
    localparam int PRIOR_AW    = $clog2(PRIOR_DEPTH);
    localparam int COND_AW     = $clog2(COND_DEPTH);

    logic [INDEX_W-1:0]  s_index;
    logic [VALUE_W-1:0]  s_value;
    logic [LETTER_W-1:0] s_letter;
    logic                s_first;
    logic                s_fire;

    logic                load_prior, load_cond, take_letter;

    logic [VALUE_W-1:0]  unseen_reg, unseen_next;
    logic [COND_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                clear_done_reg, clear_done_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_adv;

    logic                prior_we, cond_we;
    logic [PRIOR_AW-1:0] prior_wa, prior_ra;
    logic [COND_AW-1:0]  cond_wa, cond_ra;
    entry_t              wr_entry;
    entry_t              prior_rd, cond_rd;
    ctl_t                s1_ctl;

    assign s_index  = s_tdata[INDEX_W-1:0];
    assign s_value  = s_tdata[INDEX_W +: VALUE_W];
    assign s_letter = s_tdata[INDEX_W + VALUE_W +: LETTER_W];
    assign s_first  = s_tuser[2];
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        load_prior  = 1'b0;
        load_cond   = 1'b0;
        take_letter = 1'b0;
        unique case (mode_t'(s_tuser[1:0]))
            MODE_PRIOR: load_prior  = s_fire && (32'(s_index) < PRIOR_DEPTH);
            MODE_COND:  load_cond   = s_fire && (32'(s_index) < COND_DEPTH);
            MODE_TEXT:  take_letter = s_fire;
            default: ;
        endcase
    end

    // The adder stage stalls only when it holds a closing letter and the
    // result register cannot be freed this cycle.
    assign s1_adv   = s1_valid_reg && !(s1_ctl.last && m_tvalid && !m_tready);
    assign s_tready = clear_done_reg && (!s1_valid_reg || s1_adv);

    assign cfg_ready   = 1'b1;
    assign unseen_next = cfg_valid ? cfg_data : unseen_reg;

    always_comb begin
        clr_cnt_next    = clr_cnt_reg;
        clear_done_next = clear_done_reg;
        if (!clear_done_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == COND_AW'(COND_DEPTH - 1)) begin
                clear_done_next = 1'b1;
            end
        end
    end

    assign s1_valid_next = take_letter ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unseen_reg     <= UNSEEN_RESET;
            clr_cnt_reg    <= '0;
            clear_done_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end else begin
            unseen_reg     <= unseen_next;
            clr_cnt_reg    <= clr_cnt_next;
            clear_done_reg <= clear_done_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    // The clearing pass owns the write ports until it is done.
    always_comb begin
        if (!clear_done_reg) begin
            prior_we = (32'(clr_cnt_reg) < PRIOR_DEPTH);
            cond_we  = 1'b1;
            prior_wa = clr_cnt_reg[PRIOR_AW-1:0];
            cond_wa  = clr_cnt_reg;
            wr_entry = '0;
        end else begin
            prior_we = load_prior;
            cond_we  = load_cond;
            prior_wa = PRIOR_AW'(s_index);
            cond_wa  = COND_AW'(s_index);
            wr_entry = '{present: 1'b1, value: s_value};
        end
    end

    ngts_window #(
        .NGRAM_LEN (NGRAM_LEN)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take_letter),
        .letter     (s_letter),
        .first      (s_first),
        .last       (s_tlast),
        .cond_addr  (cond_ra),
        .prior_addr (prior_ra),
        .ctl        (s1_ctl)
    );

    ngts_table #(
        .DEPTH (PRIOR_DEPTH),
        .AW    (PRIOR_AW)
    ) u_prior_table (
        .aclk    (aclk),
        .wr_en   (prior_we),
        .wr_addr (prior_wa),
        .wr_data (wr_entry),
        .rd_en   (take_letter),
        .rd_addr (prior_ra),
        .rd_data (prior_rd)
    );

    ngts_table #(
        .DEPTH (COND_DEPTH),
        .AW    (COND_AW)
    ) u_cond_table (
        .aclk    (aclk),
        .wr_en   (cond_we),
        .wr_addr (cond_wa),
        .wr_data (wr_entry),
        .rd_en   (take_letter),
        .rd_addr (cond_ra),
        .rd_data (cond_rd)
    );

    ngts_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (s1_adv),
        .ctl          (s1_ctl),
        .cond_entry   (cond_rd),
        .prior_entry  (prior_rd),
        .unseen_score (unseen_reg),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    `NGTS_ASSERT_IMP(a_no_take_in_clear, !clear_done_reg, !s_tready,
        "input request taken while the tables are being cleared")
    `NGTS_ASSERT_IMP(a_stall_cause, s1_valid_reg && !s1_adv, m_tvalid && !m_tready,
        "adder stage stalled without a blocked result")
    `NGTS_ASSERT_IMP(a_result_source, $rose(m_tvalid),
        $past(s1_valid_reg && s1_adv && s1_ctl.last),
        "result appeared without a closing letter")
    `NGTS_ASSERT_NXT(a_load_leaves_stage, s_fire && !take_letter && !s1_adv, !s1_valid_reg,
        "load request left a letter in the adder stage")

endmodule

/* tb/ngram_text_scorer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngram_text_scorer_tb
// Self-checking bench for the n-gram text scorer. Table loads, ignored
// requests and letter strings go in over the input stream. String scores are
// predicted by a behavioral copy of the tables and the running sum, unless a
// directed row gives its own expected score. A directed table covers the corner
// cases, and randomized phases run under several unseen scores.
// ----------------------------------------------------------------------------
module ngram_text_scorer_tb;
    import ngts_pkg::*;

    localparam int PRIOR_DEPTH = ALPHABET ** (NGRAM_LEN_DEF - 1);
    localparam int COND_DEPTH  = PRIOR_DEPTH * ALPHABET;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam longint SUM_MAX = (longint'(1) <<< 31) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< 31);
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [1:0]                mode;
        logic [INDEX_W-1:0]        idx;
        logic signed [VALUE_W-1:0] val;
        logic [LETTER_W-1:0]       letter;
        logic                      opens;
        logic                      closes;
        logic                      typed;
        logic [SUM_W-1:0]          score;
        logic                      too_short;
    } request_t;

    typedef struct packed {
        logic [SUM_W-1:0] score;
        logic             too_short;
    } score_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SUM_W-1:0]    m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [VALUE_W-1:0]  cfg_data = '0;

    ngram_text_scorer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Behavioral copy of the scorer state.
    logic signed [VALUE_W-1:0] prior_val [PRIOR_DEPTH];
    bit                        prior_set [PRIOR_DEPTH];
    logic signed [VALUE_W-1:0] cond_val  [COND_DEPTH];
    bit                        cond_set  [COND_DEPTH];
    int unsigned               win_index = 0;
    int unsigned               seen_count = 0;
    longint                    run_sum = 0;
    logic signed [VALUE_W-1:0] unseen_q = UNSEEN_RESET;

    score_t pending_scores [$];
    int     mismatches = 0;
    int     letter_base = 0;
    bit     rx_free = 1'b0;
    int     rx_hold = 0;

    function automatic void accumulate(input logic signed [VALUE_W-1:0] v);
        run_sum = run_sum + v;
        if (run_sum > SUM_MAX) run_sum = SUM_MAX;
        if (run_sum < SUM_MIN) run_sum = SUM_MIN;
    endfunction

    function automatic void clear_string();
        win_index = 0;
        seen_count = 0;
        run_sum = 0;
    endfunction

    task automatic score_request(input request_t r, output bit emits, output score_t res);
        int unsigned ltr;
        int unsigned full;
        emits = 1'b0;
        res = '0;
        case (r.mode)
            MODE_PRIOR: begin
                if (r.idx < PRIOR_DEPTH) begin
                    prior_val[r.idx] = r.val;
                    prior_set[r.idx] = 1'b1;
                end
            end
            MODE_COND: begin
                if (r.idx < COND_DEPTH) begin
                    cond_val[r.idx] = r.val;
                    cond_set[r.idx] = 1'b1;
                end
            end
            MODE_TEXT: begin
                if (r.opens) clear_string();
                ltr = (r.letter > ALPHABET - 1) ? ALPHABET - 1 : r.letter;
                full = win_index * ALPHABET + ltr;
                if (seen_count >= NGRAM_LEN_DEF - 1) begin
                    accumulate(cond_set[full % COND_DEPTH] ? cond_val[full % COND_DEPTH]
                                                           : unseen_q);
                end
                win_index = full % PRIOR_DEPTH;
                // The prior counts once, when the opening (n-1)-gram is complete.
                if (seen_count + 1 == NGRAM_LEN_DEF - 1 && prior_set[win_index])
                    accumulate(prior_val[win_index]);
                if (seen_count < NGRAM_LEN_DEF + 1) seen_count++;
                if (r.closes) begin
                    emits = 1'b1;
                    res.score = run_sum[SUM_W-1:0];
                    res.too_short = (seen_count <= NGRAM_LEN_DEF);
                    clear_string();
                end
            end
            default: ;
        endcase
    endtask

    function automatic request_t row(input logic [1:0] md, input int idx, input int val,
                                     input int ltr, input bit opens, input bit closes,
                                     input bit typed = 1'b0, input int score = 0,
                                     input bit short_str = 1'b0);
        request_t r;
        r.mode = md;
        r.idx = idx[INDEX_W-1:0];
        r.val = val[VALUE_W-1:0];
        r.letter = ltr[LETTER_W-1:0];
        r.opens = opens;
        r.closes = closes;
        r.typed = typed;
        r.score = score;
        r.too_short = short_str;
        return r;
    endfunction

    function automatic int tx_gap(input bit quiet);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int rand_log();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return -32768;
        return -int'($urandom_range(1, 32767));
    endfunction

    // Letters cluster in a window of four so that loaded n-grams get hit.
    function automatic int pick_letter();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, ALPHABET - 1);
        return letter_base + $urandom_range(0, 3);
    endfunction

    task automatic send_request(input request_t r, input int gap);
        bit     emits;
        score_t res;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, r.letter, r.val, r.idx};
        s_tuser <= {r.opens, r.mode};
        s_tlast <= r.closes;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        score_request(r, emits, res);
        if (emits) begin
            if (r.typed) begin
                res.score = r.score;
                res.too_short = r.too_short;
            end
            pending_scores.push_back(res);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Waits until every score is back and the pipeline has drained.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_unseen(input logic signed [VALUE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        unseen_q = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count, input logic signed [VALUE_W-1:0] unseen,
                                input bit tx_quiet, input bit rx_quiet);
        request_t r;
        int       str_left;
        int       pick;
        int       a;
        int       b;
        int       c;
        int       idx;
        bit       is_cond;
        bit       opens;
        bit       closes;
        int       ltr;
        quiesce();
        write_unseen(unseen);
        rx_free <= rx_quiet;
        letter_base = $urandom_range(0, ALPHABET - 4);
        str_left = 0;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (i < 40 || pick < 30) begin
                is_cond = ($urandom_range(0, 3) != 0);
                a = pick_letter();
                b = pick_letter();
                c = pick_letter();
                case ($urandom_range(0, 19))
                    16, 17, 18: idx = $urandom_range(0, is_cond ? COND_DEPTH - 1
                                                                 : PRIOR_DEPTH - 1);
                    19: idx = $urandom_range(0, 32767);
                    default: idx = is_cond ? (a * ALPHABET + b) * ALPHABET + c
                                           : a * ALPHABET + b;
                endcase
                r = row(is_cond ? MODE_COND : MODE_PRIOR, idx, rand_log(),
                        $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (pick < 34) begin
                r = row(MODE_NONE, $urandom_range(0, 32767), rand_log(),
                        $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                opens = 1'b0;
                if (str_left == 0) begin
                    str_left = $urandom_range(1, 9);
                    opens = ($urandom_range(0, 9) != 0);
                end
                closes = (str_left == 1);
                str_left--;
                // A few letters carry arbitrary string marks.
                if ($urandom_range(0, 19) == 0) begin
                    opens = $urandom_range(0, 1);
                    closes = $urandom_range(0, 1);
                end
                ltr = ($urandom_range(0, 29) == 0) ? $urandom_range(ALPHABET, 31)
                                                   : pick_letter();
                r = row(MODE_TEXT, $urandom_range(0, 32767), rand_log(), ltr, opens, closes);
            end
            send_request(r, tx_gap(tx_quiet));
        end
    endtask

    // Receiver: always ready when rx_free is set, else mostly short stalls, now and then a long one.
    always @(posedge aclk) begin
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (rx_free) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (roll < 4) begin
            m_tready <= 1'b0;
            rx_hold <= $urandom_range(10, 40);
        end else begin
            m_tready <= (roll >= 30);
        end
    end

    always @(posedge aclk) begin
        score_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected score: expected none, actual %h too_short %b",
                         $time, m_tdata, m_tuser[0]);
            end else begin
                want = pending_scores.pop_front();
                if (m_tdata !== want.score) begin
                    mismatches++;
                    $display("%0t: total_score mismatch: expected %h, actual %h",
                             $time, want.score, m_tdata);
                end
                if (m_tuser[0] !== want.too_short) begin
                    mismatches++;
                    $display("%0t: too_short mismatch: expected %b, actual %b",
                             $time, want.too_short, m_tuser[0]);
                end
            end
        end
    end

    initial begin
        request_t directed [$];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty tables: only the unseen score counts.
        directed.push_back(row(MODE_TEXT, 0, 0, 0, 1, 0));
        directed.push_back(row(MODE_TEXT, 0, 0, 1, 0, 0));
        directed.push_back(row(MODE_TEXT, 0, 0, 2, 0, 1, 1, -32768, 1));
        // One-letter string.
        directed.push_back(row(MODE_TEXT, 0, 0, 0, 1, 1, 1, 0, 1));
        // Loads at both ends of each table and just beyond it.
        directed.push_back(row(MODE_PRIOR, 0, 0, 0, 0, 0));
        directed.push_back(row(MODE_PRIOR, PRIOR_DEPTH - 1, -32768, 0, 0, 0));
        directed.push_back(row(MODE_PRIOR, PRIOR_DEPTH, -256, 0, 0, 0));
        directed.push_back(row(MODE_COND, 0, -1, 0, 0, 0));
        directed.push_back(row(MODE_COND, COND_DEPTH - 1, -32768, 0, 0, 0));
        directed.push_back(row(MODE_COND, COND_DEPTH, -512, 0, 0, 0));
        directed.push_back(row(MODE_COND, 32767, -3, 31, 1, 1));
        directed.push_back(row(MODE_PRIOR, 32767, -5, 31, 1, 1));
        // Unused mode with every flag set must do nothing.
        directed.push_back(row(MODE_NONE, 32767, -1, 31, 1, 1));
        // "zzz" with out-of-range letters and a load in the middle of the string.
        directed.push_back(row(MODE_TEXT, 0, 0, 25, 1, 0));
        directed.push_back(row(MODE_TEXT, 0, 0, 31, 0, 0));
        directed.push_back(row(MODE_PRIOR, 1, -100, 0, 0, 0));
        directed.push_back(row(MODE_TEXT, 32767, -1, 31, 0, 1, 1, -65536, 1));
        // "aaaa" without an opening mark, right after a closed string.
        directed.push_back(row(MODE_TEXT, 0, 0, 0, 0, 0));
        directed.push_back(row(MODE_TEXT, 0, 0, 0, 0, 0));
        directed.push_back(row(MODE_TEXT, 0, 0, 0, 0, 0));
        directed.push_back(row(MODE_TEXT, 0, 0, 0, 0, 1, 1, -2, 0));
        // An opening mark in mid-string restarts it.
        directed.push_back(row(MODE_TEXT, 0, 0, 1, 0, 0));
        directed.push_back(row(MODE_TEXT, 0, 0, 2, 1, 0));
        directed.push_back(row(MODE_TEXT, 0, 0, 2, 0, 1, 1, 0, 1));
        foreach (directed[i]) send_request(directed[i], tx_gap(1'b0));

        random_phase(140, 16'sd0, 1'b0, 1'b0);
        random_phase(140, -16'sd1, 1'b1, 1'b0);
        random_phase(140, 16'(-int'($urandom_range(0, 32768))), 1'b0, 1'b1);
        random_phase(140, UNSEEN_RESET, 1'b0, 1'b0);
        random_phase(140, 16'(-int'($urandom_range(0, 32768))), 1'b0, 1'b0);

        quiesce();
        if (mismatches == 0)
            $display("ngram_text_scorer_tb passed");
        else
            $display("ngram_text_scorer_tb failed");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("ngram_text_scorer_tb failed");
        $finish;
    end

endmodule
